FILE: rtl/skt_pkg.sv
// shared types and constants for the sorted key table
// no dependencies
package skt_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LEFT_RD,
    S_LEFT_CMP,
    S_RIGHT_RD,
    S_RIGHT_CMP,
    S_RESP,
    S_LIST_RD,
    S_LIST_EMIT
  } state_e;

endpackage

FILE: rtl/skt_if.sv
// valid/ready channel interfaces for command beats and result beats
// depends on skt_pkg for field widths
interface skt_in_if
  import skt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] new_key;
  logic [VAL_W-1:0] value;

  modport source (output valid, cmd, key, new_key, value, input ready);
  modport sink   (input valid, cmd, key, new_key, value, output ready);
endinterface

interface skt_out_if
  import skt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0] entry_value;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, status, entry_key, entry_value, position, last, input ready);
  modport sink   (input valid, status, entry_key, entry_value, position, last, output ready);
endinterface

FILE: rtl/sorted_key_table_unit.sv
// Sorted key table: up to CAPACITY key/value entries kept in ascending unsigned key order in
// a single-port-read entry memory, searched and reordered by one shared 64-bit comparator.
// Insert places the new entry at the end and shifts it left past larger keys; update does a
// binary search, then moves the rewritten entry left or right. List gives one beat per entry
// while the output is taken. Each search probe or move step is a read state followed by a
// compare state, around the one registered read of the entry memory. The next command beat
// is taken once the last result is in the output register. Depends on skt_pkg and skt_if.
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skt_in_if.sink     in_if,
  skt_out_if.source  out_if
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    p_q, p_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi1_q, hi1_d;
  logic [IW-1:0]    mid_q, mid_d;
  logic [KEY_W-1:0] sk_q, sk_d;
  logic [KEY_W-1:0] mv_key_q, mv_key_d;
  logic [VAL_W-1:0] mv_val_q, mv_val_d;
  status_e          rsp_status_q, rsp_status_d;
  logic [IW-1:0]    rsp_pos_q, rsp_pos_d;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_val_q;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;

  logic             out_valid_q;
  status_e          out_status_q, out_status_d;
  logic [KEY_W-1:0] out_key_q, out_key_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic             out_last_q, out_last_d;
  logic             out_load;
  logic             out_free;

  logic [CW:0]      mid_sum;
  logic [IW-1:0]    mid_idx;
  logic [CW-1:0]    p_inc;

  logic [KEY_W-1:0] cmp_key;
  logic             key_gt;
  logic             key_lt;

  assign out_free = !out_valid_q || out_if.ready;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi1_q} - 1'b1;
  assign mid_idx  = mid_sum[IW:1];
  assign p_inc    = CW'(p_q) + 1'b1;

  // shared comparator: search key or moving key against the entry just read
  assign cmp_key  = (state_q == S_SRCH_CMP) ? sk_q : mv_key_q;
  assign key_gt   = cmp_key > rd_key_q;
  assign key_lt   = cmp_key < rd_key_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    p_d          = p_q;
    lo_d         = lo_q;
    hi1_d        = hi1_q;
    mid_d        = mid_q;
    sk_d         = sk_q;
    mv_key_d     = mv_key_q;
    mv_val_d     = mv_val_q;
    rsp_status_d = rsp_status_q;
    rsp_pos_d    = rsp_pos_q;
    rd_addr      = p_q;
    wr_en        = 1'b0;
    wr_key       = mv_key_q;
    wr_val       = mv_val_q;
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_key_d    = '0;
    out_val_d    = '0;
    out_pos_d    = '0;
    out_last_d   = 1'b1;
    in_if.ready  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          sk_d      = in_if.key;
          mv_key_d  = (cmd_e'(in_if.cmd) == CMD_INSERT) ? in_if.key : in_if.new_key;
          mv_val_d  = in_if.value;
          rsp_pos_d = '0;
          unique case (cmd_e'(in_if.cmd))
            CMD_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                rsp_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                rsp_status_d = ST_OK;
                p_d          = count_q[IW-1:0];
                count_d      = count_q + 1'b1;
                state_d      = S_LEFT_RD;
              end
            end
            CMD_UPDATE: begin
              if (count_q == '0) begin
                rsp_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                rsp_status_d = ST_OK;
                lo_d         = '0;
                hi1_d        = count_q;
                state_d      = S_SRCH_RD;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                rsp_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                p_d     = '0;
                state_d = S_LIST_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (lo_q >= hi1_q) begin
          rsp_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          rd_addr = mid_idx;
          mid_d   = mid_idx;
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (key_gt) begin
          lo_d    = CW'(mid_q) + 1'b1;
          state_d = S_SRCH_RD;
        end else if (key_lt) begin
          hi1_d   = CW'(mid_q);
          state_d = S_SRCH_RD;
        end else begin
          p_d       = mid_q;
          rsp_pos_d = mid_q;
          state_d   = S_LEFT_RD;
        end
      end
      S_LEFT_RD: begin
        if (p_q == '0) begin
          state_d = S_RIGHT_RD;
        end else begin
          rd_addr = p_q - 1'b1;
          state_d = S_LEFT_CMP;
        end
      end
      S_LEFT_CMP: begin
        if (key_lt) begin
          wr_en   = 1'b1;
          wr_key  = rd_key_q;
          wr_val  = rd_val_q;
          p_d     = p_q - 1'b1;
          state_d = S_LEFT_RD;
        end else begin
          state_d = S_RIGHT_RD;
        end
      end
      S_RIGHT_RD: begin
        if (p_inc >= count_q) begin
          wr_en   = 1'b1;
          state_d = S_RESP;
        end else begin
          rd_addr = p_q + 1'b1;
          state_d = S_RIGHT_CMP;
        end
      end
      S_RIGHT_CMP: begin
        wr_en = 1'b1;
        if (key_gt) begin
          wr_key  = rd_key_q;
          wr_val  = rd_val_q;
          p_d     = p_q + 1'b1;
          state_d = S_RIGHT_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = rsp_status_q;
          out_pos_d    = POS_W'(rsp_pos_q);
          state_d      = S_IDLE;
        end
      end
      S_LIST_RD: begin
        state_d = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_key_d  = rd_key_q;
          out_val_d  = rd_val_q;
          out_pos_d  = POS_W'(p_q);
          out_last_d = (p_inc == count_q);
          if (p_inc == count_q) begin
            state_d = S_IDLE;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = S_LIST_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    lo_q         <= lo_d;
    hi1_q        <= hi1_d;
    mid_q        <= mid_d;
    sk_q         <= sk_d;
    mv_key_q     <= mv_key_d;
    mv_val_q     <= mv_val_d;
    rsp_status_q <= rsp_status_d;
    rsp_pos_q    <= rsp_pos_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_key_q    <= out_key_d;
      out_val_q    <= out_val_d;
      out_pos_q    <= out_pos_d;
      out_last_q   <= out_last_d;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[p_q] <= wr_key;
      val_mem[p_q] <= wr_val;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = out_status_q;
  assign out_if.entry_key   = out_key_q;
  assign out_if.entry_value = out_val_q;
  assign out_if.position    = out_pos_q;
  assign out_if.last        = out_last_q;

endmodule

FILE: rtl/skt_checker.sv
// port-level checks on the sorted key table, bound into sorted_key_table_unit
// depends on skt_pkg and sorted_key_table_unit
module skt_checker
  import skt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [1:0]       in_cmd_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       out_status_i,
  input logic [KEY_W-1:0] out_key_i,
  input logic [VAL_W-1:0] out_value_i,
  input logic [POS_W-1:0] out_pos_i,
  input logic             out_last_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_key_i) && $stable(out_value_i) && $stable(out_pos_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  // error statuses are single beats with no entry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_last_i && out_key_i == '0 &&
      out_value_i == '0)
    else $error("error status beat carries data or is not last");

  // only list beats are non-final, and they are ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == ST_OK)
    else $error("non-final beat with error status");

  // a real command leaves the block busy, not ready, in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_INSERT || in_cmd_i == CMD_UPDATE ||
      in_cmd_i == CMD_LIST) |=> !in_ready_i)
    else $error("command beat taken back to back");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_cmd_i     (in_if.cmd),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.status),
  .out_key_i    (out_if.entry_key),
  .out_value_i  (out_if.entry_value),
  .out_pos_i    (out_if.position),
  .out_last_i   (out_if.last)
);

FILE: test/sorted_key_table_unit_test.sv
`timescale 1ns / 100ps
// testbench for sorted_key_table_unit: directed and random command beats, with results
// checked against a behavioural table model; depends on skt_pkg, skt_if and the unit itself
module sorted_key_table_unit_test;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 8;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 370;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic             last;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  skt_in_if  cmd_ch ();
  skt_out_if res_ch ();

  sorted_key_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (cmd_ch),
    .out_if(res_ch)
  );

  logic [KEY_W-1:0] stored_key [TABLE_DEPTH];
  logic [VAL_W-1:0] stored_val [TABLE_DEPTH];
  int               stored_count;
  table_result_t    pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      hold_cycles = 0;
  bit               no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return 64'($urandom_range(0, 7));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // adjacent-swap passes until nothing moves, so equal keys keep their order
  function automatic void reorder_table();
    bit               swapped;
    logic [KEY_W-1:0] tk;
    logic [VAL_W-1:0] tv;
    do begin
      swapped = 1'b0;
      for (int i = 0; i + 1 < stored_count; i++) begin
        if (stored_key[i] > stored_key[i+1]) begin
          tk              = stored_key[i];
          tv              = stored_val[i];
          stored_key[i]   = stored_key[i+1];
          stored_val[i]   = stored_val[i+1];
          stored_key[i+1] = tk;
          stored_val[i+1] = tv;
          swapped         = 1'b1;
        end
      end
    end while (swapped);
  endfunction

  function automatic int search_table(logic [KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = stored_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (k > stored_key[mid]) lo = mid + 1;
      else if (k < stored_key[mid]) hi = mid - 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic void predict_table_cmd(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [KEY_W-1:0] new_key,
                                            logic [VAL_W-1:0] value);
    table_result_t res;
    int            hit;
    res = '{status: ST_OK, key: '0, value: '0, pos: '0, last: 1'b1};
    case (cmd)
      CMD_INSERT: begin
        if (stored_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stored_key[stored_count] = key;
          stored_val[stored_count] = value;
          stored_count++;
          reorder_table();
        end
        pending_results.push_back(res);
      end
      CMD_UPDATE: begin
        if (stored_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = search_table(key);
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            stored_key[hit] = new_key;
            stored_val[hit] = value;
            reorder_table();
            res.pos = hit[POS_W-1:0];
          end
        end
        pending_results.push_back(res);
      end
      CMD_LIST: begin
        if (stored_count == 0) begin
          res.status = ST_EMPTY;
          pending_results.push_back(res);
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            res.key   = stored_key[i];
            res.value = stored_val[i];
            res.pos   = i[POS_W-1:0];
            res.last  = (i + 1 == stored_count);
            pending_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: check every accepted beat, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d key %h value %h pos %0d last %0b",
                 $time, res_ch.status, res_ch.entry_key, res_ch.entry_value,
                 res_ch.position, res_ch.last);
        mismatch_count++;
      end else begin
        report_field("status", 64'(pending_results[0].status), 64'(res_ch.status));
        report_field("entry_key", pending_results[0].key, res_ch.entry_key);
        report_field("entry_value", pending_results[0].value, res_ch.entry_value);
        report_field("position", 64'(pending_results[0].pos), 64'(res_ch.position));
        report_field("last", 64'(pending_results[0].last), 64'(res_ch.last));
        void'(pending_results.pop_front());
      end
    end
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      res_ch.ready <= 1'b1;
      hold_cycles = pick_gap();
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [KEY_W-1:0] key,
                           logic [KEY_W-1:0] new_key, logic [VAL_W-1:0] value);
    int unsigned gap;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.cmd     <= cmd;
    cmd_ch.key     <= key;
    cmd_ch.new_key <= new_key;
    cmd_ch.value   <= value;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predict_table_cmd(cmd, key, new_key, value);
    gap = pick_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_empty_table();
    send_beat(CMD_LIST, '0, '0, '0);
    send_beat(CMD_UPDATE, '1, '1, '1);
    send_beat(CMD_UNUSED, '1, '1, '1);
  endtask

  task automatic test_insert_extremes();
    send_beat(CMD_INSERT, '1, '0, '1);
    send_beat(CMD_INSERT, '0, '0, '0);
    // equal keys must keep their arrival order
    send_beat(CMD_INSERT, '0, '1, 64'h5555_5555_5555_5555);
    send_beat(CMD_INSERT, 64'h8000_0000_0000_0000, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(CMD_LIST, '0, '0, '0);
  endtask

  task automatic test_update_search();
    send_beat(CMD_UPDATE, 64'd1, '0, '1);
    // duplicate key: the midpoint probe picks which copy is rewritten
    send_beat(CMD_UPDATE, '0, '1, 64'h0123_4567_89AB_CDEF);
    send_beat(CMD_UPDATE, '1, '0, 64'hFEDC_BA98_7654_3210);
    send_beat(CMD_LIST, '0, '0, '0);
  endtask

  task automatic test_full_table();
    send_beat(CMD_INSERT, 64'd7, '0, 64'h1111_2222_3333_4444);
    send_beat(CMD_INSERT, 64'd7, '0, 64'h5555_6666_7777_8888);
    send_beat(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '1);
    send_beat(CMD_INSERT, 64'd1, '0, 64'd9);
    send_beat(CMD_INSERT, 64'd2, '0, 64'd3);
    send_beat(CMD_LIST, '0, '0, '0);
    send_beat(CMD_UPDATE, 64'd7, 64'd1, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned      r;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      no_idle = (n >= 120 && n < 170);
      r = $urandom_range(0, 99);
      if (r < 20) cmd = CMD_INSERT;
      else if (r < 72) cmd = CMD_UPDATE;
      else if (r < 95) cmd = CMD_LIST;
      else cmd = CMD_UNUSED;
      k = pick_key();
      if (cmd == CMD_UPDATE && stored_count != 0 && $urandom_range(0, 3) != 0)
        k = stored_key[$urandom_range(0, stored_count - 1)];
      nk = pick_key();
      send_beat(cmd, k, nk, {$urandom(), $urandom()});
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.cmd     <= CMD_INSERT;
    cmd_ch.key     <= '0;
    cmd_ch.new_key <= '0;
    cmd_ch.value   <= '0;
    stored_count   = 0;
    no_idle        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_insert_extremes();
    test_update_search();
    test_full_table();
    test_random_traffic();

    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
